### rtl/nrf_pkg.sv
package nrf_pkg;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 11;
    localparam int CFG_W   = 12;
    localparam int WIN_N   = 9;
    localparam int NB_N    = 8;
    localparam int EMIT_N  = 4;

    typedef enum logic [1:0] {
        MODE_MIN    = 2'd0,
        MODE_MAX    = 2'd1,
        MODE_MID    = 2'd2,
        MODE_MEDIAN = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_index_t;

    // Window position flags of the input pixel that made a task
    typedef struct packed {
        logic i0;
        logic i1;
        logic ilast;
        logic j0;
        logic j1;
        logic jlast;
    } pos_flags_t;

    // One queued task: window snapshot plus up to four results to emit
    typedef struct packed {
        logic [WIN_N-1:0][PIX_W-1:0] win;
        logic [EMIT_N-1:0]           emit;
        logic [POS_W-1:0]            row;
        logic [POS_W-1:0]            col;
        pos_flags_t                  flags;
    } task_t;

endpackage

### rtl/nrf_if.sv
interface pixel_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface result_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  value;
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic        last;
    logic        frame_done;

    modport source (output valid, output value, output out_row, output out_col,
                    output last, output frame_done, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input last, input frame_done, output ready);
endinterface

### rtl/nrf_ram.sv
module nrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and write at one address return the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nrf_front.sv
module nrf_front
    import nrf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pixel_in_if.sink                      pix,
    input  logic                          restart,
    input  logic [$clog2(MAX_WIDTH)-1:0]  w_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0] h_last,
    output logic                          push,
    output task_t                         push_task,
    input  logic                          q_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          accept;

    // stage 1: accepted word waiting for line store data
    logic               f1_valid_reg, f1_valid_next;
    logic [PIX_W-1:0]   f1_pix_reg;
    logic               f1_par_reg;
    logic [POS_W-1:0]   f1_row_reg, f1_col_reg;
    pos_flags_t         f1_flags_reg, flags;
    logic [EMIT_N-1:0]  f1_emit_reg, emit;
    logic               f1_adv;

    logic [WIN_N-1:0][PIX_W-1:0] win_reg, win_next;
    logic [PIX_W-1:0]            rd0, rd1, old_px, prev_px;

    // line store banks, one per row parity
    nrf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
        .clk   (clk),
        .we    (accept && !row_reg[0]),
        .waddr (col_reg),
        .wdata (pix.pixel),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd0)
    );

    nrf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
        .clk   (clk),
        .we    (accept && row_reg[0]),
        .waddr (col_reg),
        .wdata (pix.pixel),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd1)
    );

    assign f1_adv    = f1_valid_reg && (f1_emit_reg == '0 || !q_full);
    assign pix.ready = !f1_valid_reg || f1_adv;
    assign accept    = pix.valid && pix.ready;

    // position flags and results this word releases
    always_comb
    begin
        flags.i0    = (row_reg == '0);
        flags.i1    = (row_reg == RW'(1));
        flags.ilast = (row_reg == h_last);
        flags.j0    = (col_reg == '0);
        flags.j1    = (col_reg == CW'(1));
        flags.jlast = (col_reg == w_last);
        emit[0] = !flags.i0 && !flags.j0;
        emit[1] = !flags.i0 && flags.jlast;
        emit[2] = flags.ilast && !flags.j0;
        emit[3] = flags.ilast && flags.jlast;
    end

    // raster position
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (flags.jlast)
            begin
                col_next = '0;
                row_next = flags.ilast ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    assign f1_valid_next = accept ? 1'b1 : (f1_adv ? 1'b0 : f1_valid_reg);

    // window shift with the two line store words and the new pixel
    always_comb
    begin
        old_px  = f1_par_reg ? rd1 : rd0;
        prev_px = f1_par_reg ? rd0 : rd1;
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = old_px;
        win_next[5] = prev_px;
        win_next[8] = f1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            f1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            f1_valid_reg <= f1_valid_next;
            if (f1_adv)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_pix_reg   <= pix.pixel;
            f1_par_reg   <= row_reg[0];
            f1_row_reg   <= POS_W'(row_reg);
            f1_col_reg   <= POS_W'(col_reg);
            f1_flags_reg <= flags;
            f1_emit_reg  <= emit;
        end
    end

    assign push            = f1_adv && (f1_emit_reg != '0);
    assign push_task.win   = win_next;
    assign push_task.emit  = f1_emit_reg;
    assign push_task.row   = f1_row_reg;
    assign push_task.col   = f1_col_reg;
    assign push_task.flags = f1_flags_reg;

endmodule

### rtl/nrf_queue.sv
module nrf_queue
    import nrf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_task,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output task_t head_task
);

    localparam int PW = $clog2(DEPTH);

    task_t            ent_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [PW:0]      cnt_reg;

    assign full       = (cnt_reg == (PW+1)'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_task  = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= push_task;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH-1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH-1)) ? '0 : rptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (PW+1)'(1);
            end
        end
    end

endmodule

### rtl/nrf_back.sv
module nrf_back
    import nrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  mode,
    input  logic        head_valid,
    input  task_t       head_task,
    output logic        pop,
    result_out_if.source res
);

    logic [EMIT_N-1:0] done_reg, done_next, pend;
    logic [1:0]        sel;
    logic              is_last, back_en;

    // stage B1: gathered neighbors of one result
    logic                        b1_valid_reg;
    logic [NB_N-1:0][PIX_W-1:0]  b1_val_reg, nb_val;
    logic [NB_N-1:0]             b1_mask_reg, nb_mask;
    logic [POS_W-1:0]            b1_row_reg, b1_col_reg;
    logic                        b1_last_reg, b1_fd_reg;

    // output register
    logic              o_valid_reg;
    logic [PIX_W-1:0]  o_value_reg, stat;
    logic [POS_W-1:0]  o_row_reg, o_col_reg;
    logic              o_last_reg, o_fd_reg;

    assign back_en = !o_valid_reg || res.ready;

    // pick the lowest result of the head task not yet issued
    always_comb
    begin
        pend = head_task.emit & ~done_reg;
        sel  = 2'd0;
        for (int k = EMIT_N-1; k >= 0; k--)
        begin
            if (pend[k])
            begin
                sel = 2'(k);
            end
        end
        is_last = ((pend >> (sel + 2'd1)) == '0) || (sel == 2'd3);
    end

    assign pop = back_en && head_valid && is_last;

    always_comb
    begin
        done_next = done_reg;
        if (back_en && head_valid)
        begin
            done_next = is_last ? '0 : (done_reg | (EMIT_N'(1) << sel));
        end
    end

    // neighbor gather for window center (wr, wc)
    always_comb
    begin
        int  wr, wc, r, c, n;
        logic top, bot, lft, rgt, ok;
        wr  = sel[1] ? 2 : 1;
        wc  = sel[0] ? 2 : 1;
        top = sel[1] ? head_task.flags.i0 : head_task.flags.i1;
        bot = sel[1];
        lft = sel[0] ? head_task.flags.j0 : head_task.flags.j1;
        rgt = sel[0];
        n   = 0;
        nb_val  = '0;
        nb_mask = '0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (!(dr == 0 && dc == 0))
                begin
                    r  = wr + dr;
                    c  = wc + dc;
                    ok = !((dr < 0 && top) || (dr > 0 && bot) ||
                           (dc < 0 && lft) || (dc > 0 && rgt)) && r <= 2 && c <= 2;
                    nb_mask[n] = ok;
                    nb_val[n]  = ok ? head_task.win[ok ? (r*3 + c) : 0] : '0;
                    n++;
                end
            end
        end
    end

    // statistic over the gathered neighbors
    always_comb
    begin
        logic [PIX_W-1:0] lo, hi, med;
        logic [3:0]       cnt, rank;
        lo  = '1;
        hi  = '0;
        med = '0;
        cnt = 4'($countones(b1_mask_reg));
        for (int k = 0; k < NB_N; k++)
        begin
            if (b1_mask_reg[k] && b1_val_reg[k] < lo)
            begin
                lo = b1_val_reg[k];
            end
            if (b1_mask_reg[k] && b1_val_reg[k] > hi)
            begin
                hi = b1_val_reg[k];
            end
        end
        // rank with index as tie break; upper median sits at rank cnt/2
        for (int k = 0; k < NB_N; k++)
        begin
            rank = '0;
            for (int m = 0; m < NB_N; m++)
            begin
                if (b1_mask_reg[m] && (b1_val_reg[m] < b1_val_reg[k] ||
                    (b1_val_reg[m] == b1_val_reg[k] && m < k)))
                begin
                    rank = rank + 4'd1;
                end
            end
            if (b1_mask_reg[k] && rank == (cnt >> 1))
            begin
                med = b1_val_reg[k];
            end
        end
        unique case (mode_t'(mode))
            MODE_MIN:    stat = lo;
            MODE_MAX:    stat = hi;
            MODE_MID:    stat = (hi >> 1) + (lo >> 1);
            MODE_MEDIAN: stat = med;
            default:     stat = med;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            b1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (back_en)
            begin
                b1_valid_reg <= head_valid;
                o_valid_reg  <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b1_val_reg  <= nb_val;
            b1_mask_reg <= nb_mask;
            b1_row_reg  <= sel[1] ? head_task.row : head_task.row - POS_W'(1);
            b1_col_reg  <= sel[0] ? head_task.col : head_task.col - POS_W'(1);
            b1_last_reg <= is_last;
            b1_fd_reg   <= (sel == 2'd3);
            o_value_reg <= stat;
            o_row_reg   <= b1_row_reg;
            o_col_reg   <= b1_col_reg;
            o_last_reg  <= b1_last_reg;
            o_fd_reg    <= b1_fd_reg;
        end
    end

    assign res.valid      = o_valid_reg;
    assign res.value      = o_value_reg;
    assign res.out_row    = o_row_reg;
    assign res.out_col    = o_col_reg;
    assign res.last       = o_last_reg;
    assign res.frame_done = o_fd_reg;

endmodule

### rtl/neighbor_rank_filter_3x3_core.sv
// 3x3 neighbor rank filter over a raster stream of 8-bit gray pixels. One pixel word is
// taken per clock unless the queue is full; each pixel's result (min, max, midpoint or
// upper median of its in-frame neighbors, center excluded) leaves once its last neighbor
// has arrived, so the stream of results lags the input by one row and one column. A
// pixel releases zero to four result words (four at the last pixel of a 2x2 or larger
// frame); results leave at one word per clock while the result port is ready, so a row
// end releases an extra word and the last row doubles the output words. Input pace is
// set by the result port: a four-entry task queue between the line-store front and the
// statistic back end absorbs those bursts. Results pass the front register, the queue,
// stage B1 and the output register. Line store: two banks of MAX_WIDTH bytes, one per
// row parity, no clear pass needed. Geometry writes restart the frame at row 0, column 0.
module neighbor_rank_filter_3x3_core
    import nrf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    pixel_in_if.sink         pix,
    result_out_if.source     res,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [1:0]       mode_reg;
    logic [CFG_W-1:0] fw_reg, fh_reg;
    logic             restart;
    logic [CW-1:0]    w_last;
    logic [RW-1:0]    h_last;
    logic             push, q_full, pop, head_valid;
    task_t            push_task, head_task;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MEDIAN;
            fw_reg   <= CFG_W'(640);
            fh_reg   <= CFG_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:   mode_reg <= cfg_data[1:0];
                CFG_WIDTH:  fw_reg   <= cfg_data;
                CFG_HEIGHT: fh_reg   <= cfg_data;
                CFG_NONE:   ;
                default:    ;
            endcase
        end
    end

    assign restart = cfg_we && (cfg_index_t'(cfg_index) == CFG_WIDTH ||
                                cfg_index_t'(cfg_index) == CFG_HEIGHT);

    // saturate geometry to 1..MAX, keep last index
    always_comb
    begin
        int w, h;
        w = int'(fw_reg);
        h = int'(fh_reg);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        w_last = CW'(w - 1);
        h_last = RW'(h - 1);
    end

    nrf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .restart   (restart),
        .w_last    (w_last),
        .h_last    (h_last),
        .push      (push),
        .push_task (push_task),
        .q_full    (q_full)
    );

    nrf_queue #(.DEPTH(4)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_task  (push_task),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_task  (head_task)
    );

    nrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .head_valid (head_valid),
        .head_task  (head_task),
        .pop        (pop),
        .res        (res)
    );

endmodule

### dv/nrf_checker.sv
`timescale 1ns / 1ps

module nrf_checker
    import nrf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    pixel_in_if              pix,
    result_out_if            res,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last;
        logic             frame_done;
    } rank_result_t;

    // expected result words, oldest first
    rank_result_t rank_results_q[$];

    // predicted block state
    logic [PIX_W-1:0] rows_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    mode_t            cur_mode;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    assign pending = rank_results_q.size();

    function automatic int unsigned sat_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // statistic over the in-frame neighbors of (orow, ocol), center left out
    function automatic logic [PIX_W-1:0] neighbor_stat(int wr, int wc, int unsigned orow,
            int unsigned ocol, int unsigned w, int unsigned h);
        logic [PIX_W-1:0] nb [8];
        logic [PIX_W-1:0] t;
        int unsigned      lo;
        int unsigned      hi;
        int               n;
        int               b;
        n  = 0;
        lo = 255;
        hi = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (dr == 0 && dc == 0) continue;
                if (dr < 0 && orow == 0) continue;
                if (dr > 0 && orow + 1 >= h) continue;
                if (dc < 0 && ocol == 0) continue;
                if (dc > 0 && ocol + 1 >= w) continue;
                if (wr + dr < 0 || wr + dr > 2 || wc + dc < 0 || wc + dc > 2) continue;
                nb[n] = win[wr+dr][wc+dc];
                n++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            if (nb[k] < lo) lo = nb[k];
            if (nb[k] > hi) hi = nb[k];
        end
        case (cur_mode)
            MODE_MIN: return lo[PIX_W-1:0];
            MODE_MAX: return hi[PIX_W-1:0];
            MODE_MID: return PIX_W'(hi / 2 + lo / 2);
            default:  ;
        endcase
        // no neighbors: median fixed to zero
        if (n == 0)
            return '0;
        for (int a = 1; a < n; a++)
        begin
            t = nb[a];
            b = a - 1;
            while (b >= 0 && nb[b] > t)
            begin
                nb[b+1] = nb[b];
                b--;
            end
            nb[b+1] = t;
        end
        return nb[n/2];
    endfunction

    // take in one pixel word, queue the results it releases
    function automatic void rank_step(logic [PIX_W-1:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  i;
        int unsigned  j;
        int unsigned  old_slot;
        int unsigned  prev_slot;
        int unsigned  rr [4];
        int unsigned  cc [4];
        int           wr [4];
        int           wc [4];
        int           n;
        rank_result_t r;
        w = sat_dim(width_reg, MAX_WIDTH);
        h = sat_dim(height_reg, MAX_HEIGHT);
        i = row_pos;
        j = col_pos;
        n = 0;
        if (i >= h || j >= w)
        begin
            i = 0;
            j = 0;
        end
        old_slot  = (i & 1) * MAX_WIDTH + j;
        prev_slot = ((i + 1) & 1) * MAX_WIDTH + j;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = rows_mem[old_slot];
        win[1][2] = rows_mem[prev_slot];
        win[2][2] = px;
        rows_mem[old_slot] = px;

        if (i >= 1 && j >= 1)
        begin
            rr[n] = i - 1; cc[n] = j - 1; wr[n] = 1; wc[n] = 1; n++;
        end
        if (i >= 1 && j == w - 1)
        begin
            rr[n] = i - 1; cc[n] = j; wr[n] = 1; wc[n] = 2; n++;
        end
        if (i == h - 1 && j >= 1)
        begin
            rr[n] = i; cc[n] = j - 1; wr[n] = 2; wc[n] = 1; n++;
        end
        if (i == h - 1 && j == w - 1)
        begin
            rr[n] = i; cc[n] = j; wr[n] = 2; wc[n] = 2; n++;
        end
        for (int k = 0; k < n; k++)
        begin
            r.value      = neighbor_stat(wr[k], wc[k], rr[k], cc[k], w, h);
            r.out_row    = rr[k][POS_W-1:0];
            r.out_col    = cc[k][POS_W-1:0];
            r.last       = (k == n - 1);
            r.frame_done = (rr[k] == h - 1 && cc[k] == w - 1);
            rank_results_q.push_back(r);
        end

        j++;
        if (j >= w)
        begin
            j = 0;
            i++;
            if (i >= h) i = 0;
        end
        row_pos = i;
        col_pos = j;
    endfunction

    // compare one result word with the oldest expectation
    function automatic void check_result();
        rank_result_t e;
        if (rank_results_q.size() == 0)
        begin
            $error("unexpected result word row %0d col %0d", res.out_row, res.out_col);
            fail_count++;
            return;
        end
        e = rank_results_q.pop_front();
        if (res.value !== e.value)
        begin
            $error("value: expected %0d actual %0d", e.value, res.value);
            fail_count++;
        end
        if (res.out_row !== e.out_row)
        begin
            $error("out_row: expected %0d actual %0d", e.out_row, res.out_row);
            fail_count++;
        end
        if (res.out_col !== e.out_col)
        begin
            $error("out_col: expected %0d actual %0d", e.out_col, res.out_col);
            fail_count++;
        end
        if (res.last !== e.last)
        begin
            $error("last: expected %0d actual %0d", e.last, res.last);
            fail_count++;
        end
        if (res.frame_done !== e.frame_done)
        begin
            $error("frame_done: expected %0d actual %0d", e.frame_done, res.frame_done);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2*MAX_WIDTH; k++) rows_mem[k] = '0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++) win[a][b] = '0;
            row_pos    = 0;
            col_pos    = 0;
            cur_mode   = MODE_MEDIAN;
            width_reg  = CFG_W'(640);
            height_reg = CFG_W'(480);
            fail_count = 0;
            rank_results_q.delete();
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:
                        cur_mode = mode_t'(cfg_data[1:0]);
                    CFG_WIDTH:
                    begin
                        width_reg = cfg_data;
                        row_pos   = 0;
                        col_pos   = 0;
                    end
                    CFG_HEIGHT:
                    begin
                        height_reg = cfg_data;
                        row_pos    = 0;
                        col_pos    = 0;
                    end
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                rank_step(pix.pixel);
        end
    end

endmodule

### dv/tb_neighbor_rank_filter_3x3_core.sv
`timescale 1ns / 1ps

module tb_neighbor_rank_filter_3x3_core;
    import nrf_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    int               random_words;
    bit               calm;       // no idling on either side
    bit               hold_req;   // ask the receiver for a long hold-off

    pixel_in_if   pix ();
    result_out_if res ();

    neighbor_rank_filter_3x3_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nrf_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result receiver: random stalls, optional long hold-off
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res.ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_req = 1'b0;
            end
            res.ready <= calm || ($urandom_range(99) >= 18);
        end
    end

    // offer one pixel word, keep valid high back to back unless idling
    task automatic send_pixel(logic [7:0] p);
        if (!calm && $urandom_range(99) < 9)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        do @(posedge clk); while (!pix.ready);
    endtask

    // stop sending and wait until every expected word is out
    task automatic drain();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic set_frame(mode_t m, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        drain();
        write_reg(CFG_MODE, CFG_W'(m));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned n;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_NONE;
        cfg_data  = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-pixel frame: no neighbors, every mode
        for (int m = 0; m < 4; m++)
        begin
            set_frame(mode_t'(m), 12'd1, 12'd1);
            send_pixel(8'd0);
            send_pixel(8'd255);
        end

        // 3x3 frame: corners, edges and interior, extremes of the pixel
        set_frame(MODE_MEDIAN, 12'd3, 12'd3);
        send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd1);
        send_pixel(8'd128); send_pixel(8'd127); send_pixel(8'd254);
        send_pixel(8'd85);  send_pixel(8'd170); send_pixel(8'd255);
        set_frame(MODE_MID, 12'd3, 12'd3);
        for (int k = 0; k < 9; k++) send_pixel(k[0] ? 8'd255 : 8'd0);

        // out-of-range geometry saturates: widest row, single row
        set_frame(MODE_MAX, 12'hFFF, 12'd0);
        for (int k = 0; k < 20; k++) send_pixel(8'($urandom));
        // single column, tallest frame
        set_frame(MODE_MIN, 12'd0, 12'd2048);
        for (int k = 0; k < 16; k++) send_pixel(8'($urandom));
        // widest frame, two rows deep
        set_frame(MODE_MEDIAN, 12'd2048, 12'd2);
        for (int k = 0; k < 12; k++) send_pixel(8'($urandom));

        // random small frames, partial frames and restarts
        random_words = 0;
        for (int ph = 0; ph < 4 || random_words < 96; ph++)
        begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            set_frame(mode_t'($urandom_range(3)), CFG_W'(w), CFG_W'(h));
            calm = (ph == 2);
            n = w * h + $urandom_range(0, 2 * w);
            // long hold-off and long no-idle stretch need enough words
            if (ph == 1 || ph == 2) n = n + 16;
            for (int k = 0; k < n; k++)
            begin
                if (ph == 1 && k == 0) hold_req = 1'b1;
                if (ph == 3 && k == n / 2) drain();
                send_pixel($urandom_range(9) == 0 ? 8'($urandom_range(1) * 255)
                                                  : 8'($urandom));
                random_words++;
            end
            calm = 1'b0;
        end

        // wait for all results, bounded
        pix.valid <= 1'b0;
        for (int k = 0; k < 20000 && pending != 0; k++) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/nrf_pkg.sv
rtl/nrf_if.sv
rtl/nrf_ram.sv
rtl/nrf_front.sv
rtl/nrf_queue.sv
rtl/nrf_back.sv
rtl/neighbor_rank_filter_3x3_core.sv
dv/nrf_checker.sv
dv/tb_neighbor_rank_filter_3x3_core.sv
